// ----- design/esfs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esfs_pkg
// Types, codes and constants shared by the eased screen fade sequencer.
// ----------------------------------------------------------------------------
package esfs_pkg;

    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [15:0] FADE_MS_RESET  = 16'd500;
    localparam logic [15:0] PAUSE_MS_RESET = 16'd500;
    localparam int          DIV_STEPS      = 16;

    // configuration register indexes
    localparam logic CFG_FADE_MS  = 1'b0;
    localparam logic CFG_PAUSE_MS = 1'b1;

    // operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // start modes
    localparam logic [1:0] MODE_FADE_IN  = 2'd0;
    localparam logic [1:0] MODE_FADE_OUT = 2'd1;
    localparam logic [1:0] MODE_OUT_IN   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE           = 3'd0,
        PH_IN             = 3'd1,
        PH_OUT            = 3'd2,
        PH_OUT_THEN_PAUSE = 3'd3,
        PH_PAUSE          = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_OUT_DONE   = 2'd1,
        EV_PAUSE_DONE = 2'd2,
        EV_FINISHED   = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_DIV  = 3'd1,
        S_SQ   = 3'd2,
        S_CUBE = 3'd3,
        S_STEP = 3'd4,
        S_EMIT = 3'd5
    } seq_state_t;

    typedef struct packed {
        logic       operation;
        logic [1:0] start_mode;
        logic [9:0] tick_ms;
    } in_item_t;

    typedef struct packed {
        logic [16:0] alpha;
        logic        fade_active;
        logic [1:0]  phase_event;
        logic        start_rejected;
    } out_item_t;

endpackage
`default_nettype wire

// ----- design/eased_screen_fade_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eased_screen_fade_sequencer
// Fade in / fade out / fade-pause-fade sequencer with ease-out-cubic alpha.
// ----------------------------------------------------------------------------
// One request in, one result out. A start request or a tick while idle goes
// from accept to the emit state; a tick during a pause passes the timer
// update first. A fade tick passes divide, square, cube and timer update
// (no divide when the fraction is already one): a restoring divider yields
// the elapsed fraction one quotient bit per cycle, then one shared
// multiplier forms the square and then the cube of the remaining fraction.
// The input is not ready while a request is in work; a finished result
// waits in the output register and the block returns to ready once it is
// loaded there. Register writes take effect from the next phase that begins.
module eased_screen_fade_sequencer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire esfs_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output esfs_pkg::out_item_t       out_data,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import esfs_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    seq_state_t  state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [15:0] len_reg, len_next;
    logic [16:0] alpha_reg, alpha_next;
    logic [9:0]  tick_reg, tick_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0] v_reg, v_next;
    logic [49:0] mul_reg, mul_next;
    out_item_t   res_reg, res_next;
    out_item_t   out_data_reg, out_data_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] fade_reg, pause_reg;

    logic [32:0] mul_a;
    logic [49:0] mul_p;
    logic [16:0] trial;
    logic [16:0] cube;
    logic [17:0] sum;
    logic        accept;
    logic        out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // shared multiplier: square first, then square times v
    assign mul_a = (state_reg == S_SQ) ? {16'd0, v_reg} : mul_reg[32:0];
    assign mul_p = {17'd0, mul_a} * {33'd0, v_reg};
    assign cube  = mul_p[48:32];

    assign trial = {rem_reg[15:0], 1'b0};
    assign sum   = {1'b0, elapsed_reg} + {8'd0, tick_reg};

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        len_next       = len_reg;
        alpha_next     = alpha_reg;
        tick_next      = tick_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        v_next         = v_reg;
        mul_next       = mul_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tick_next  = in_data.tick_ms;
                    state_next = S_EMIT;
                    res_next   = '0;
                    if (in_data.operation == OP_START)
                    begin
                        if (phase_reg != PH_IDLE)
                        begin
                            res_next.alpha          = alpha_reg;
                            res_next.fade_active    = 1'b1;
                            res_next.start_rejected = 1'b1;
                        end
                        else if (in_data.start_mode inside {MODE_FADE_IN, MODE_FADE_OUT,
                                                            MODE_OUT_IN})
                        begin
                            case (in_data.start_mode)
                                MODE_FADE_IN:  phase_next = PH_IN;
                                MODE_FADE_OUT: phase_next = PH_OUT;
                                default:       phase_next = PH_OUT_THEN_PAUSE;
                            endcase
                            elapsed_next = '0;
                            len_next     = fade_reg;
                            alpha_next   = (in_data.start_mode == MODE_FADE_IN) ?
                                           17'd0 : ONE_Q16;
                            res_next.alpha       = alpha_next;
                            res_next.fade_active = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_PAUSE)
                    begin
                        state_next = S_STEP;
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        // fraction is one when the length is zero or reached
                        if (len_reg == 16'd0 || elapsed_reg >= {1'b0, len_reg})
                        begin
                            v_next     = '0;
                            state_next = S_SQ;
                        end
                        else
                        begin
                            rem_next   = elapsed_reg;
                            quo_next   = '0;
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (trial >= {1'b0, len_reg})
                begin
                    rem_next = trial - {1'b0, len_reg};
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    v_next     = ONE_Q16 - {1'b0, quo_next};
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                mul_next   = mul_p;
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                alpha_next = (phase_reg == PH_IN) ? (ONE_Q16 - cube) : cube;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                res_next = '0;
                elapsed_next = sum[16:0];
                if (sum[16:0] >= {1'b0, len_reg})
                begin
                    elapsed_next = '0;
                    case (phase_reg)
                        PH_OUT_THEN_PAUSE:
                        begin
                            phase_next           = PH_PAUSE;
                            len_next             = pause_reg;
                            res_next.phase_event = EV_OUT_DONE;
                        end
                        PH_PAUSE:
                        begin
                            phase_next           = PH_IN;
                            len_next             = fade_reg;
                            res_next.phase_event = EV_PAUSE_DONE;
                        end
                        default:
                        begin
                            phase_next           = PH_IDLE;
                            len_next             = '0;
                            res_next.phase_event = EV_FINISHED;
                        end
                    endcase
                end
                if (phase_next != PH_IDLE)
                begin
                    res_next.alpha       = alpha_reg;
                    res_next.fade_active = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            len_reg       <= '0;
            alpha_reg     <= '0;
            out_valid_reg <= 1'b0;
            fade_reg      <= FADE_MS_RESET;
            pause_reg     <= PAUSE_MS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            len_reg       <= len_next;
            alpha_reg     <= alpha_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FADE_MS:  fade_reg  <= cfg_data;
                    CFG_PAUSE_MS: pause_reg <= cfg_data;
                    default:      fade_reg  <= fade_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg     <= tick_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        v_reg        <= v_next;
        mul_reg      <= mul_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < {1'b0, len_reg})
        else $error("divider remainder out of range");

    // timer never rests at or past the phase length
    a_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && phase_reg != PH_IDLE) |->
            (elapsed_reg < {1'b0, len_reg} || elapsed_reg == 17'd0))
        else $error("fade timer past phase length");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        alpha_reg <= ONE_Q16)
        else $error("alpha above one");

    // cube result always goes on to the timer update
    a_cube_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CUBE |=> state_reg == S_STEP)
        else $error("sequencer skipped timer update");

endmodule
`default_nettype wire
